FILE: rtl/url_query_decoder_top_macros.svh
// assertion macros shared by the url query decoder checkers
`ifndef URL_QUERY_DECODER_TOP_MACROS_SVH
`define URL_QUERY_DECODER_TOP_MACROS_SVH

// property sampled on clk, ignored while reset is asserted
`define UQD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("url query decoder check failed");

// implication form of the above
`define UQD_ASSERT_IMP(lbl, pre, post) \
	`UQD_ASSERT(lbl, (pre) |-> (post))

`endif

FILE: rtl/uqd_pkg.sv
// shared types, constants and hex digit function of the url query decoder
package uqd_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_PATH,
		PH_NAME,
		PH_VALUE,
		PH_ESC1,
		PH_ESC2,
		PH_SKIP
	} phase_t;

	// field kind codes
	localparam logic [1:0] KIND_PATH  = 2'd0;
	localparam logic [1:0] KIND_NAME  = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// delimiter bytes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	// one decoded result word
	typedef struct packed {
		logic [1:0] kind;
		logic       has_char;
		logic [7:0] decoded_char;
		logic       field_end;
		logic       param_end;
		logic       url_end;
	} result_t;

	// parser state carried between bytes
	typedef struct packed {
		phase_t     phase;
		logic [3:0] high_nibble;
	} state_t;

	// value of one escape digit; non-hex bytes wrap as byte minus '0'
	function automatic logic [7:0] hex_value(input logic [7:0] b);
		logic [7:0] v;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			v = b - CH_ZERO;
		end else if (b >= CH_UP_A && b <= CH_UP_F) begin
			v = b - CH_UP_A + HEX_TEN;
		end else if (b >= CH_LO_A && b <= CH_LO_F) begin
			v = b - CH_LO_A + HEX_TEN;
		end else begin
			v = b - CH_ZERO;
		end
		return v;
	endfunction

endpackage

FILE: rtl/uqd_step.sv
// next-state and result logic for one url byte
module uqd_step (
	input  uqd_pkg::state_t  cur,
	input  logic [7:0]       url_byte,
	input  logic             is_last,
	output uqd_pkg::state_t  nxt,
	output uqd_pkg::result_t res,
	output logic             emit
);

	uqd_pkg::phase_t post;
	logic [7:0]      hv;
	logic [3:0]      nib;

	assign hv = uqd_pkg::hex_value(url_byte);

	// per-phase decode, then closing rules for the last byte
	always_comb begin
		res          = '0;
		emit         = 1'b1;
		post         = cur.phase;
		nib          = cur.high_nibble;
		res.url_end  = is_last;
		case (cur.phase)
			uqd_pkg::PH_PATH: begin
				res.kind = uqd_pkg::KIND_PATH;
				if (url_byte == uqd_pkg::CH_SPACE) begin
					res.field_end = 1'b1;
					post = uqd_pkg::PH_SKIP;
				end else if (url_byte == uqd_pkg::CH_QUEST) begin
					res.field_end = 1'b1;
					post = uqd_pkg::PH_NAME;
				end else begin
					res.has_char = 1'b1;
					res.decoded_char = url_byte;
				end
			end
			uqd_pkg::PH_NAME: begin
				res.kind = uqd_pkg::KIND_NAME;
				if (url_byte == uqd_pkg::CH_SPACE) begin
					res.field_end = 1'b1;
					res.param_end = 1'b1;
					post = uqd_pkg::PH_SKIP;
				end else if (url_byte == uqd_pkg::CH_EQUAL) begin
					res.field_end = 1'b1;
					post = uqd_pkg::PH_VALUE;
				end else if (url_byte == uqd_pkg::CH_AMP) begin
					res.field_end = 1'b1;
					res.param_end = 1'b1;
				end else begin
					res.has_char = 1'b1;
					res.decoded_char = url_byte;
				end
			end
			uqd_pkg::PH_VALUE: begin
				res.kind = uqd_pkg::KIND_VALUE;
				if (url_byte == uqd_pkg::CH_SPACE) begin
					res.field_end = 1'b1;
					res.param_end = 1'b1;
					post = uqd_pkg::PH_SKIP;
				end else if (url_byte == uqd_pkg::CH_AMP) begin
					res.field_end = 1'b1;
					res.param_end = 1'b1;
					post = uqd_pkg::PH_NAME;
				end else if (url_byte == uqd_pkg::CH_PLUS) begin
					res.has_char = 1'b1;
					res.decoded_char = uqd_pkg::CH_SPACE;
				end else if (url_byte == uqd_pkg::CH_PERCENT) begin
					emit = 1'b0;
					post = uqd_pkg::PH_ESC1;
				end else begin
					res.has_char = 1'b1;
					res.decoded_char = url_byte;
				end
			end
			uqd_pkg::PH_ESC1: begin
				res.kind = uqd_pkg::KIND_VALUE;
				emit = 1'b0;
				post = uqd_pkg::PH_ESC2;
				nib = hv[3:0];
			end
			uqd_pkg::PH_ESC2: begin
				res.kind = uqd_pkg::KIND_VALUE;
				res.has_char = 1'b1;
				res.decoded_char = {cur.high_nibble, 4'h0} + hv;
				post = uqd_pkg::PH_VALUE;
			end
			default: begin
				emit = 1'b0;
				post = uqd_pkg::PH_SKIP;
			end
		endcase

		// last byte closes the open field and restarts the parser
		if (is_last) begin
			emit = 1'b1;
			case (post)
				uqd_pkg::PH_PATH: res.field_end = 1'b1;
				uqd_pkg::PH_NAME: begin
					if (res.kind == uqd_pkg::KIND_NAME && res.has_char) begin
						res.field_end = 1'b1;
						res.param_end = 1'b1;
					end
				end
				uqd_pkg::PH_VALUE, uqd_pkg::PH_ESC1, uqd_pkg::PH_ESC2: begin
					if (res.kind == uqd_pkg::KIND_NAME) begin
						res.param_end = 1'b1;
					end else begin
						res.kind = uqd_pkg::KIND_VALUE;
						res.field_end = 1'b1;
						res.param_end = 1'b1;
					end
				end
				default: ;
			endcase
			nxt.phase       = uqd_pkg::PH_PATH;
			nxt.high_nibble = 4'h0;
		end else begin
			nxt.phase       = post;
			nxt.high_nibble = nib;
		end
	end

endmodule

FILE: rtl/url_query_decoder_top.sv
// top level of the streaming url query decoder
// Takes one url byte per cycle while in_ready is high and returns at most one tagged
// result word per byte, marking path, parameter name and parameter value characters
// with percent and plus decoding applied. A byte is captured in an input register
// and decoded by shallow logic into a result register, so throughput is one byte per
// clock while the output is not stalled. The parser state advances as each byte
// moves from the input register to the result register; a full result register
// that is not taken holds the input register, which in turn drops in_ready.
// Bytes that produce no result ('%', the first escape digit, bytes after a space)
// pass through without occupying the result register.
module url_query_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] url_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic       has_char,
	output logic [7:0] decoded_char,
	output logic       field_end,
	output logic       param_end,
	output logic       url_end
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	uqd_pkg::state_t  state_q;
	uqd_pkg::state_t  state_nxt;
	uqd_pkg::result_t res_nxt;
	uqd_pkg::result_t res_q;
	logic             res_valid_q;
	logic             emit;
	logic             out_free;
	logic             advance;

	// handshake control
	assign out_free = !res_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= url_byte;
			last_s1 <= is_last;
		end
	end

	// decode of the held byte
	uqd_step u_step (
		.cur      (state_q),
		.url_byte (byte_s1),
		.is_last  (last_s1),
		.nxt      (state_nxt),
		.res      (res_nxt),
		.emit     (emit)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= uqd_pkg::PH_PATH;
			state_q.high_nibble <= 4'h0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_nxt;
		end
	end

	// output word
	assign out_valid    = res_valid_q;
	assign kind         = res_q.kind;
	assign has_char     = res_q.has_char;
	assign decoded_char = res_q.decoded_char;
	assign field_end    = res_q.field_end;
	assign param_end    = res_q.param_end;
	assign url_end      = res_q.url_end;

endmodule

FILE: rtl/uqd_checker.sv
// port-level checks for the url query decoder and their binding
`include "url_query_decoder_top_macros.svh"

module uqd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] url_byte,
	input logic       is_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic       has_char,
	input logic [7:0] decoded_char,
	input logic       field_end,
	input logic       param_end,
	input logic       url_end
);

	// kind is one of path, name or value
	`UQD_ASSERT_IMP(a_kind_legal, out_valid, kind <= uqd_pkg::KIND_VALUE)

	// a word without a character carries a zero byte
	`UQD_ASSERT_IMP(a_char_zero, out_valid && !has_char, decoded_char == 8'h00)

	// a finished pair always closes a name or value field
	`UQD_ASSERT_IMP(a_pair_closes, out_valid && param_end, field_end && kind != uqd_pkg::KIND_PATH)

	// a stalled word holds its contents
	`UQD_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(decoded_char) && $stable(kind) && $stable(url_end)))

	// an offered input word waits unchanged until taken
	`UQD_ASSERT_IMP(a_in_hold, in_valid && !in_ready, ##1 (in_valid && $stable(url_byte) && $stable(is_last)))

endmodule

bind url_query_decoder_top uqd_checker u_uqd_checker (.*);

FILE: tb/tb_url_query_decoder_top.sv
// self-checking testbench for the streaming url query decoder
module tb_url_query_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS = 1300;
	localparam int LONG_HOLD  = 300;
	localparam int HOLD_AFTER = 300;
	localparam int DRAIN_WAIT = 8;
	localparam int DIR_N      = 26;

	// one input word and one row of the directed table
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} byte_in_t;

	typedef struct packed {
		logic [7:0]       b;
		logic             last;
		logic             typed;
		uqd_pkg::result_t exp;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] url_byte = 8'h00;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic       has_char;
	logic [7:0] decoded_char;
	logic       field_end;
	logic       param_end;
	logic       url_end;

	// expectation carried alongside a directed word
	logic             row_typed = 1'b0;
	uqd_pkg::result_t row_exp = '0;

	// decoder shadow state and bookkeeping
	uqd_pkg::phase_t  pred_phase = uqd_pkg::PH_PATH;
	logic [3:0]       pred_nibble = 4'h0;
	uqd_pkg::result_t pending [$];
	byte_in_t         url_bytes [$];
	int               mismatches = 0;
	int               live_items = 0;
	int               words_in = 0;
	int               words_out = 0;
	int               urls_sent = 0;

	// directed words: reset, byte extremes, every delimiter, escapes, url endings
	dir_row_t dir_rows [DIR_N] = '{
		'{8'h61, 1'b0, 1'b1, '{uqd_pkg::KIND_PATH, 1'b1, 8'h61, 1'b0, 1'b0, 1'b0}}, // a
		'{8'hFF, 1'b0, 1'b1, '{uqd_pkg::KIND_PATH, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
		'{8'h00, 1'b0, 1'b1, '{uqd_pkg::KIND_PATH, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
		'{uqd_pkg::CH_QUEST, 1'b0, 1'b1,
			'{uqd_pkg::KIND_PATH, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
		'{8'h6E, 1'b0, 1'b0, '0},      // n
		'{uqd_pkg::CH_AMP, 1'b0, 1'b0, '0},
		'{8'h6B, 1'b0, 1'b0, '0},      // k
		'{uqd_pkg::CH_EQUAL, 1'b0, 1'b0, '0},
		'{uqd_pkg::CH_PLUS, 1'b0, 1'b0, '0},
		'{uqd_pkg::CH_PERCENT, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},      // 4
		'{8'h61, 1'b0, 1'b0, '0},      // a, lowercase digit
		'{uqd_pkg::CH_PERCENT, 1'b0, 1'b0, '0},
		'{8'h46, 1'b0, 1'b0, '0},      // F
		'{8'h66, 1'b0, 1'b0, '0},      // f
		'{uqd_pkg::CH_PERCENT, 1'b0, 1'b0, '0},
		'{8'h7A, 1'b0, 1'b0, '0},      // z, non-hex digit
		'{uqd_pkg::CH_SPACE, 1'b0, 1'b0, '0},   // space taken as escape digit
		'{uqd_pkg::CH_AMP, 1'b0, 1'b0, '0},
		'{uqd_pkg::CH_EQUAL, 1'b0, 1'b0, '0},   // empty name
		'{uqd_pkg::CH_SPACE, 1'b0, 1'b0, '0},   // ends the url
		'{8'h72, 1'b1, 1'b1, '{uqd_pkg::KIND_PATH, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
		'{uqd_pkg::CH_QUEST, 1'b0, 1'b0, '0},
		'{8'h61, 1'b0, 1'b0, '0},
		'{uqd_pkg::CH_EQUAL, 1'b0, 1'b0, '0},
		'{uqd_pkg::CH_PERCENT, 1'b1, 1'b1,
			'{uqd_pkg::KIND_VALUE, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1}}
	};

	url_query_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.url_byte     (url_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.has_char     (has_char),
		.decoded_char (decoded_char),
		.field_end    (field_end),
		.param_end    (param_end),
		.url_end      (url_end)
	);

	always #5 clk = ~clk;

	// hex digit value, other bytes wrap as byte minus '0'
	function automatic logic [7:0] digit_of(input logic [7:0] b);
		if (b inside {[uqd_pkg::CH_UP_A:uqd_pkg::CH_UP_F]})
			return b - uqd_pkg::CH_UP_A + uqd_pkg::HEX_TEN;
		if (b inside {[uqd_pkg::CH_LO_A:uqd_pkg::CH_LO_F]})
			return b - uqd_pkg::CH_LO_A + uqd_pkg::HEX_TEN;
		return b - uqd_pkg::CH_ZERO;
	endfunction

	// advance the shadow parser by one byte; returns 1 when a word comes out
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
			output uqd_pkg::result_t r);
		uqd_pkg::phase_t nxt;
		logic [7:0]      dv;
		bit              emit;
		r = '0;
		emit = 1'b1;
		dv = digit_of(b);
		nxt = pred_phase;
		case (pred_phase)
			uqd_pkg::PH_PATH: begin
				if (b == uqd_pkg::CH_SPACE) begin
					r.field_end = 1'b1;
					nxt = uqd_pkg::PH_SKIP;
				end else if (b == uqd_pkg::CH_QUEST) begin
					r.field_end = 1'b1;
					nxt = uqd_pkg::PH_NAME;
				end else begin
					r.has_char = 1'b1;
					r.decoded_char = b;
				end
			end
			uqd_pkg::PH_NAME: begin
				r.kind = uqd_pkg::KIND_NAME;
				if (b == uqd_pkg::CH_SPACE) begin
					r.field_end = 1'b1;
					r.param_end = 1'b1;
					nxt = uqd_pkg::PH_SKIP;
				end else if (b == uqd_pkg::CH_EQUAL) begin
					r.field_end = 1'b1;
					nxt = uqd_pkg::PH_VALUE;
				end else if (b == uqd_pkg::CH_AMP) begin
					r.field_end = 1'b1;
					r.param_end = 1'b1;
				end else begin
					r.has_char = 1'b1;
					r.decoded_char = b;
				end
			end
			uqd_pkg::PH_VALUE: begin
				r.kind = uqd_pkg::KIND_VALUE;
				if (b == uqd_pkg::CH_SPACE) begin
					r.field_end = 1'b1;
					r.param_end = 1'b1;
					nxt = uqd_pkg::PH_SKIP;
				end else if (b == uqd_pkg::CH_AMP) begin
					r.field_end = 1'b1;
					r.param_end = 1'b1;
					nxt = uqd_pkg::PH_NAME;
				end else if (b == uqd_pkg::CH_PLUS) begin
					r.has_char = 1'b1;
					r.decoded_char = uqd_pkg::CH_SPACE;
				end else if (b == uqd_pkg::CH_PERCENT) begin
					emit = 1'b0;
					nxt = uqd_pkg::PH_ESC1;
				end else begin
					r.has_char = 1'b1;
					r.decoded_char = b;
				end
			end
			uqd_pkg::PH_ESC1: begin
				r.kind = uqd_pkg::KIND_VALUE;
				emit = 1'b0;
				pred_nibble = dv[3:0];
				nxt = uqd_pkg::PH_ESC2;
			end
			uqd_pkg::PH_ESC2: begin
				r.kind = uqd_pkg::KIND_VALUE;
				r.has_char = 1'b1;
				r.decoded_char = {pred_nibble, 4'h0} + dv;
				nxt = uqd_pkg::PH_VALUE;
			end
			default: begin
				emit = 1'b0;
				nxt = uqd_pkg::PH_SKIP;
			end
		endcase
		// last byte closes whatever field is open
		if (last) begin
			emit = 1'b1;
			r.url_end = 1'b1;
			case (nxt)
				uqd_pkg::PH_PATH: r.field_end = 1'b1;
				uqd_pkg::PH_NAME: begin
					if (r.kind == uqd_pkg::KIND_NAME && r.has_char) begin
						r.field_end = 1'b1;
						r.param_end = 1'b1;
					end
				end
				uqd_pkg::PH_VALUE, uqd_pkg::PH_ESC1, uqd_pkg::PH_ESC2: begin
					r.param_end = 1'b1;
					if (r.kind != uqd_pkg::KIND_NAME) begin
						r.kind = uqd_pkg::KIND_VALUE;
						r.field_end = 1'b1;
					end
				end
				default: ;
			endcase
			pred_phase = uqd_pkg::PH_PATH;
			pred_nibble = 4'h0;
		end else begin
			pred_phase = nxt;
		end
		return emit;
	endfunction

	task automatic check_field(input string fname, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// score output words, then predict from accepted input words
	always @(posedge clk) begin
		uqd_pkg::result_t want;
		uqd_pkg::result_t pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				words_out++;
				if (pending.size() == 0) begin
					$display("%0t ns: unexpected word kind %0d char %0h", $time, kind,
						decoded_char);
					mismatches++;
				end else begin
					want = pending.pop_front();
					check_field("kind", 8'(want.kind), 8'(kind));
					check_field("has_char", 8'(want.has_char), 8'(has_char));
					check_field("decoded_char", want.decoded_char, decoded_char);
					check_field("field_end", 8'(want.field_end), 8'(field_end));
					check_field("param_end", 8'(want.param_end), 8'(param_end));
					check_field("url_end", 8'(want.url_end), 8'(url_end));
				end
			end
			if (in_valid && in_ready) begin
				words_in++;
				if (pred_phase != uqd_pkg::PH_SKIP)
					live_items++;
				if (decode_byte(url_byte, is_last, pred))
					pending.push_back(row_typed ? row_exp : pred);
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// random idle pattern with stretches of none
	function automatic int next_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 99) < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if ($urandom_range(0, 99) < 35)
			return pick_gap();
		return 0;
	endfunction

	// url byte generators
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom);
		c = 8'($urandom_range(33, 126));
		if (c inside {uqd_pkg::CH_QUEST, uqd_pkg::CH_EQUAL, uqd_pkg::CH_AMP,
				uqd_pkg::CH_PLUS, uqd_pkg::CH_PERCENT})
			c = 8'h5F;
		return c;
	endfunction

	function automatic logic [7:0] hex_char();
		int v;
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		v = $urandom_range(0, 21);
		if (v < 10)
			return uqd_pkg::CH_ZERO + 8'(v);
		if (v < 16)
			return uqd_pkg::CH_UP_A + 8'(v - 10);
		return uqd_pkg::CH_LO_A + 8'(v - 16);
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 11))
			0: return uqd_pkg::CH_SPACE;
			1: return uqd_pkg::CH_QUEST;
			2: return uqd_pkg::CH_EQUAL;
			3: return uqd_pkg::CH_AMP;
			4: return uqd_pkg::CH_PLUS;
			5: return uqd_pkg::CH_PERCENT;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		url_bytes.push_back(byte_in_t'{b, 1'b0});
	endtask

	// one url: mostly path?name=value&... with random content, some noise or cut short
	task automatic build_url();
		int npairs;
		int cut;
		url_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) add_byte(noise_byte());
		end else begin
			repeat ($urandom_range(0, 6)) add_byte(plain_char());
			if ($urandom_range(0, 9) != 0) begin
				add_byte(uqd_pkg::CH_QUEST);
				npairs = $urandom_range(0, 3);
				for (int k = 0; k < npairs; k++) begin
					if (k > 0)
						add_byte(uqd_pkg::CH_AMP);
					repeat ($urandom_range(0, 4)) add_byte(plain_char());
					if ($urandom_range(0, 4) != 0) begin
						add_byte(uqd_pkg::CH_EQUAL);
						repeat ($urandom_range(0, 5)) begin
							case ($urandom_range(0, 9))
								0, 1: add_byte(uqd_pkg::CH_PLUS);
								2, 3: begin
									add_byte(uqd_pkg::CH_PERCENT);
									add_byte(hex_char());
									add_byte(hex_char());
								end
								default: add_byte(plain_char());
							endcase
						end
					end
				end
			end
			if ($urandom_range(0, 1) == 1) begin
				add_byte(uqd_pkg::CH_SPACE);
				repeat ($urandom_range(0, 3)) add_byte(noise_byte());
			end
			if (url_bytes.size() > 1 && $urandom_range(0, 6) == 0) begin
				cut = $urandom_range(1, url_bytes.size() - 1);
				url_bytes = url_bytes[0:cut-1];
			end
		end
		if (url_bytes.size() == 0)
			add_byte(plain_char());
		url_bytes[url_bytes.size()-1].last = 1'b1;
	endtask

	// offer one word at a falling edge and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
			input uqd_pkg::result_t exp, inout int calm);
		int gap;
		gap = next_idle(calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		url_byte <= b;
		is_last <= last;
		row_typed <= typed;
		row_exp <= exp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sender: reset, directed table, random urls, drain
	initial begin
		int calm_tx;
		calm_tx = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp,
				calm_tx);
		while (live_items < RAND_ITEMS) begin
			build_url();
			foreach (url_bytes[i])
				send_byte(url_bytes[i].b, url_bytes[i].last, 1'b0, '0, calm_tx);
			urls_sent++;
		end
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("sent %0d bytes in %0d random urls after %0d directed bytes", words_in,
			urls_sent, DIR_N);
		$display("checked %0d result words, including one long output hold-off",
			words_out);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// receiver: random stalls plus one long hold-off that backs up the input
	initial begin
		int calm_rx;
		int stall_left;
		bit held_long;
		calm_rx = 0;
		stall_left = 0;
		held_long = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_long && words_in >= HOLD_AFTER) begin
				held_long = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = next_idle(calm_rx);
			end
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/uqd_pkg.sv
rtl/uqd_step.sv
rtl/url_query_decoder_top.sv
rtl/uqd_checker.sv
tb/tb_url_query_decoder_top.sv
